// ===== sv/rnvp_pkg.sv =====
`timescale 1ns / 1ps

package rnvp_pkg;

    // Payload widths
    localparam int CH_W    = 8;
    localparam int VALUE_W = 12;
    localparam int CODE_W  = 3;
    localparam int EPOS_W  = 5;
    localparam int NDIG    = 7;
    localparam int CNT_W   = 3;

    typedef logic [2:0]         t_digit;
    typedef logic [CODE_W-1:0]  t_code;
    typedef logic [VALUE_W-1:0] t_value;
    typedef logic [CNT_W-1:0]   t_count;

    // Digit indexes
    localparam t_digit DIG_I    = 3'd0;
    localparam t_digit DIG_V    = 3'd1;
    localparam t_digit DIG_X    = 3'd2;
    localparam t_digit DIG_L    = 3'd3;
    localparam t_digit DIG_C    = 3'd4;
    localparam t_digit DIG_D    = 3'd5;
    localparam t_digit DIG_M    = 3'd6;
    localparam t_digit DIG_NONE = 3'd7;

    // Error codes
    localparam t_code ERR_NONE      = 3'd0;
    localparam t_code ERR_INVALID   = 3'd1;
    localparam t_code ERR_ORDER     = 3'd2;
    localparam t_code ERR_REUSED    = 3'd3;
    localparam t_code ERR_COMBO     = 3'd4;
    localparam t_code ERR_TOO_MANY  = 3'd5;

    localparam t_count CNT_MAX = 3'd7;

    // Per-digit tables, the unused slot holds the no-digit entry
    localparam t_value DIG_VAL [8] = '{
        12'd1, 12'd5, 12'd10, 12'd50, 12'd100, 12'd500, 12'd1000, 12'd0
    };
    // Value added by the second digit of a subtractive pair ending in this digit
    localparam t_value SUB_DELTA [8] = '{
        12'd0, 12'd3, 12'd8, 12'd30, 12'd80, 12'd300, 12'd800, 12'd0
    };
    // Allowed subtractor for this digit
    localparam t_digit DIG_SUB [8] = '{
        DIG_NONE, DIG_I, DIG_I, DIG_X, DIG_X, DIG_C, DIG_C, DIG_NONE
    };
    localparam t_count DIG_MAX [8] = '{
        3'd3, 3'd1, 3'd3, 3'd1, 3'd3, 3'd1, 3'd3, 3'd0
    };

    // ASCII to digit index
    function automatic t_digit decode_digit(input logic [CH_W-1:0] ch);
        t_digit d;
        unique case (ch)
            8'h49:   d = DIG_I;
            8'h56:   d = DIG_V;
            8'h58:   d = DIG_X;
            8'h4C:   d = DIG_L;
            8'h43:   d = DIG_C;
            8'h44:   d = DIG_D;
            8'h4D:   d = DIG_M;
            default: d = DIG_NONE;
        endcase
        return d;
    endfunction

endpackage

// ===== sv/rnvp_if.sv =====
`timescale 1ns / 1ps

// Character request channel
interface rnvp_in_if import rnvp_pkg::*; ;
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] ch;
    logic            last;

    modport source (output valid, ch, last, input ready);
    modport sink   (input valid, ch, last, output ready);
endinterface

// Result request channel
interface rnvp_out_if import rnvp_pkg::*; ;
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;
    logic [CODE_W-1:0]  error_code;
    logic [EPOS_W-1:0]  error_position;

    modport source (output valid, value, error_code, error_position, input ready);
    modport sink   (input valid, value, error_code, error_position, output ready);
endinterface

// ===== sv/roman_numeral_validating_parser_core.sv =====
`timescale 1ns / 1ps

// Roman numeral parser: takes one ASCII character per request on i_in, with
// last set on the final character, and returns one result on o_out per
// numeral: the value (I V X L C D M, subtractive pairs allowed), an error code
// and the zero-based position of the first bad character. Characters after an
// error, and characters at index MAX_CHARS or beyond, are ignored; the
// reported position saturates at 31. The block takes one character per
// cycle unless a last character waits in the input register for a full
// result register that is not being read: the parse state update (digit
// counts, subtractor flags, previous digit, running value) is a loop behind
// the input register; a result is registered as its last character leaves
// it. A waiting result does not stop next-numeral characters from entering.
module roman_numeral_validating_parser_core
    import rnvp_pkg::*;
#(
    parameter int MAX_CHARS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rnvp_in_if.sink     i_in,
    rnvp_out_if.source  o_out
);

    localparam int POS_W = $clog2(MAX_CHARS + 1);

    // Input register
    logic            r_in_valid;
    logic [CH_W-1:0] r_in_ch;
    logic            r_in_last;

    // Parse state
    t_count          r_cnt [NDIG];
    logic [NDIG-1:0] r_su;
    t_digit          r_prev;
    t_value          r_run;
    t_code           r_err;
    logic [POS_W-1:0] r_pos;

    // Result register
    logic              r_out_valid;
    t_value            r_out_value;
    t_code             r_out_code;
    logic [EPOS_W-1:0] r_out_pos;

    logic adv;

    // Next state
    t_count           n_cnt [NDIG];
    logic [NDIG-1:0]  n_su;
    t_digit           n_prev;
    t_value           n_run;
    t_code            n_err;
    logic [POS_W-1:0] n_pos;

    // Step decode
    t_digit          dig;
    logic [NDIG-1:0] dig_oh;
    logic [NDIG-1:0] prev_oh;
    t_count          cnt_r;
    t_count          cnt_p;
    t_count          cnt_r_inc;
    logic            su_r;
    logic            combo_bad;
    logic            is_sub;
    logic            active;
    t_code           step_err;
    logic [VALUE_W:0] sum;
    logic [POS_W+EPOS_W-1:0] pos_ext;

    // Handshakes
    assign adv         = r_in_valid && (!r_in_last || !r_out_valid || o_out.ready);
    assign i_in.ready  = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_ch   <= i_in.ch;
            r_in_last <= i_in.last;
        end
    end

    // One parse step on the registered character
    always_comb begin
        dig     = decode_digit(r_in_ch);
        active  = (r_err == ERR_NONE) && (r_pos < POS_W'(MAX_CHARS));
        cnt_r   = '0;
        cnt_p   = '0;
        for (int i = 0; i < NDIG; i++) begin
            dig_oh[i]  = (dig == t_digit'(i));
            prev_oh[i] = (r_prev == t_digit'(i));
            cnt_r      = cnt_r | (dig_oh[i] ? r_cnt[i] : '0);
            cnt_p      = cnt_p | (prev_oh[i] ? r_cnt[i] : '0);
        end
        su_r      = |(r_su & dig_oh);
        cnt_r_inc = (cnt_r == CNT_MAX) ? CNT_MAX : cnt_r + 3'd1;
        // V, L, D after their own subtractor already served in a pair
        combo_bad = (dig == DIG_V && r_su[DIG_I]) || (dig == DIG_L && r_su[DIG_X]) ||
                    (dig == DIG_D && r_su[DIG_C]);
        is_sub    = (dig > r_prev);

        if (dig == DIG_NONE) begin
            step_err = ERR_INVALID;
        end else if (is_sub) begin
            step_err = (DIG_SUB[dig] != r_prev || cnt_p > 3'd1) ? ERR_ORDER : ERR_NONE;
        end else if (su_r) begin
            step_err = ERR_REUSED;
        end else if (combo_bad) begin
            step_err = ERR_COMBO;
        end else if (cnt_r_inc > DIG_MAX[dig]) begin
            step_err = ERR_TOO_MANY;
        end else begin
            step_err = ERR_NONE;
        end

        sum = {1'b0, r_run} + {1'b0, is_sub ? SUB_DELTA[dig] : DIG_VAL[dig]};

        n_cnt  = r_cnt;
        n_su   = r_su;
        n_prev = r_prev;
        n_run  = r_run;
        n_err  = r_err;
        n_pos  = r_pos;
        if (active) begin
            if (step_err != ERR_NONE) begin
                n_err = step_err;
            end else begin
                for (int i = 0; i < NDIG; i++) begin
                    if (dig_oh[i]) begin
                        n_cnt[i] = cnt_r_inc;
                    end else if (is_sub && prev_oh[i] && r_cnt[i] != '0) begin
                        n_cnt[i] = r_cnt[i] - 3'd1;
                    end
                end
                if (is_sub) begin
                    n_su = r_su | prev_oh;
                end
                n_prev = dig;
                n_run  = sum[VALUE_W] ? '1 : sum[VALUE_W-1:0];
                n_pos  = r_pos + POS_W'(1);
            end
        end
        pos_ext = {{EPOS_W{1'b0}}, n_pos};
    end

    // Parse state registers, cleared after the last character
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (adv && r_in_last)) begin
            for (int i = 0; i < NDIG; i++) begin
                r_cnt[i] <= '0;
            end
            r_su   <= '0;
            r_prev <= DIG_M;
            r_run  <= '0;
            r_err  <= ERR_NONE;
            r_pos  <= '0;
        end else if (adv) begin
            r_cnt  <= n_cnt;
            r_su   <= n_su;
            r_prev <= n_prev;
            r_run  <= n_run;
            r_err  <= n_err;
            r_pos  <= n_pos;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_in_last) begin
            if (n_err == ERR_NONE) begin
                r_out_value <= n_run;
                r_out_code  <= ERR_NONE;
                r_out_pos   <= '0;
            end else begin
                r_out_value <= '0;
                r_out_code  <= n_err;
                r_out_pos   <= (pos_ext > (POS_W+EPOS_W)'(31)) ? EPOS_W'(31)
                                                               : pos_ext[EPOS_W-1:0];
            end
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.value          = r_out_value;
    assign o_out.error_code     = r_out_code;
    assign o_out.error_position = r_out_pos;

    // State is back at reset values after a numeral closes
    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && r_in_last |=> r_prev == DIG_M && r_run == '0 && r_err == ERR_NONE
                             && r_pos == '0 && r_su == '0)
        else $error("parse state not cleared after last character");

    // A latched error holds until the numeral closes
    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err != ERR_NONE && !(adv && r_in_last) |=> r_err == $past(r_err))
        else $error("latched error changed mid numeral");

    // Failed numerals report no value, good ones no position
    a_result_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_code == ERR_NONE ? r_out_pos == '0 : r_out_value == '0))
        else $error("result fields inconsistent with error code");

    // Error codes stay within the defined set
    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out_code <= ERR_TOO_MANY)
        else $error("undefined error code");

endmodule
